// File: rtl/sorted_list_merge_engine_macros.svh
// ----------------------------------------------------------------------------
// sorted_list_merge_engine_macros
// Assertion macros for the sorted list merge engine.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_MERGE_ENGINE_MACROS_SVH
`define SORTED_LIST_MERGE_ENGINE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SLME_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slme assertion failed");
`define SLME_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slme assertion failed");
`else
`define SLME_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SLME_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/slme_pkg.sv
// ----------------------------------------------------------------------------
// slme_pkg
// Shared types and constants of the sorted list merge engine.
// ----------------------------------------------------------------------------
package slme_pkg;

    localparam int DEPTH  = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int K_W    = $clog2(2 * DEPTH + 1);

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_UNSORTED = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic               list_sel;
        logic signed [31:0] value;
        logic               end_of_list;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] merged_value;
        logic               last;
        logic [1:0]         status;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic err;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic completes;
        logic unsorted;
        logic last_step;
    } t_stat;

endpackage

// File: rtl/slme_ctrl.sv
// ----------------------------------------------------------------------------
// slme_ctrl
// Sequencer: load phase, read setup, merge output phase.
// ----------------------------------------------------------------------------
module slme_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  slme_pkg::t_stat i_stat,
    output slme_pkg::t_cmd  o_cmd,
    output logic           o_busy
);
    import slme_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PRIME,
        S_MERGE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.completes) begin
                        n_state = S_PRIME;
                    end
                end
            end
            S_PRIME: begin
                if (i_stat.unsorted) begin
                    o_cmd.err = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    n_state = S_MERGE;
                end
            end
            S_MERGE: begin
                o_cmd.step = 1'b1;
                if (i_stat.last_step) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_busy = r_busy;

endmodule

// File: rtl/slme_dp.sv
// ----------------------------------------------------------------------------
// slme_dp
// List stores, counters, order check and merge selection.
// ----------------------------------------------------------------------------
module slme_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  slme_pkg::t_cmd        i_cmd,
    input  slme_pkg::t_in_item    i_item,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_data,
    output slme_pkg::t_stat       o_stat,
    output slme_pkg::t_out_item   o_result,
    output logic                  o_result_valid
);
    import slme_pkg::*;

    logic [31:0] mem_a [DEPTH];
    logic [31:0] mem_b [DEPTH];

    logic [CNT_W-1:0]   r_cnt_a, r_cnt_b, n_cnt_a, n_cnt_b;
    logic               r_done_a, r_done_b, n_done_a, n_done_b;
    logic               r_ovf, n_ovf;
    logic               r_unsorted, n_unsorted;
    logic               r_dup;
    logic [CNT_W-1:0]   r_i, r_j, n_i, n_j;
    logic [K_W-1:0]     r_k, n_k;
    logic signed [31:0] r_last_a, r_last_b;
    logic signed [31:0] r_rd_a, r_rd_b;
    t_out_item          r_out, n_out;
    logic               r_out_valid, n_out_valid;

    logic               sel_done, other_done, sel_room, sel_wr;
    logic [CNT_W-1:0]   sel_cnt;
    logic               sel_desc;
    logic [K_W-1:0]     total;
    logic               last_step;
    logic               ha, hb;

    assign sel_done   = i_item.list_sel ? r_done_b : r_done_a;
    assign other_done = i_item.list_sel ? r_done_a : r_done_b;
    assign sel_cnt    = i_item.list_sel ? r_cnt_b : r_cnt_a;
    assign sel_room   = (sel_cnt < CNT_W'(DEPTH));
    assign sel_wr     = i_cmd.load && !sel_done && sel_room;
    assign sel_desc   = (sel_cnt != '0) &&
                        (i_item.value < (i_item.list_sel ? r_last_b : r_last_a));

    assign total     = K_W'(r_cnt_a) + K_W'(r_cnt_b);
    assign last_step = (r_k == total - K_W'(1));
    assign ha        = (r_i < r_cnt_a);
    assign hb        = (r_j < r_cnt_b);

    assign o_stat.completes = !sel_done && i_item.end_of_list && other_done;
    assign o_stat.unsorted  = r_unsorted;
    assign o_stat.last_step = last_step;

    always_comb begin
        n_cnt_a     = r_cnt_a;
        n_cnt_b     = r_cnt_b;
        n_done_a    = r_done_a;
        n_done_b    = r_done_b;
        n_ovf       = r_ovf;
        n_unsorted  = r_unsorted;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_out       = r_out;
        n_out_valid = 1'b0;

        if (i_cmd.load && !sel_done) begin
            if (sel_room) begin
                if (sel_desc) begin
                    n_unsorted = 1'b1;
                end
                if (i_item.list_sel) begin
                    n_cnt_b = r_cnt_b + CNT_W'(1);
                end else begin
                    n_cnt_a = r_cnt_a + CNT_W'(1);
                end
            end else begin
                n_ovf = 1'b1;
            end
            if (i_item.end_of_list) begin
                if (i_item.list_sel) begin
                    n_done_b = 1'b1;
                end else begin
                    n_done_a = 1'b1;
                end
            end
        end

        if (i_cmd.err) begin
            n_out_valid        = 1'b1;
            n_out.merged_value = '0;
            n_out.last         = 1'b1;
            n_out.status       = ST_UNSORTED;
        end

        if (i_cmd.step) begin
            n_out_valid  = 1'b1;
            n_out.last   = last_step;
            n_out.status = r_ovf ? ST_OVERFLOW : ST_OK;
            n_k          = r_k + K_W'(1);
            priority if (ha && hb) begin
                if (r_dup && (r_rd_a == r_rd_b)) begin
                    n_out.merged_value = r_rd_b;
                    n_i = r_i + CNT_W'(1);
                    n_j = r_j + CNT_W'(1);
                end else if (r_rd_a <= r_rd_b) begin
                    n_out.merged_value = r_rd_a;
                    n_i = r_i + CNT_W'(1);
                end else begin
                    n_out.merged_value = r_rd_b;
                    n_j = r_j + CNT_W'(1);
                end
            end else if (ha) begin
                n_out.merged_value = r_rd_a;
                n_i = r_i + CNT_W'(1);
            end else if (hb) begin
                n_out.merged_value = r_rd_b;
                n_j = r_j + CNT_W'(1);
            end else begin
                n_out.merged_value = '0;
            end
        end

        if (i_cmd.err || (i_cmd.step && last_step)) begin
            n_cnt_a    = '0;
            n_cnt_b    = '0;
            n_done_a   = 1'b0;
            n_done_b   = 1'b0;
            n_ovf      = 1'b0;
            n_unsorted = 1'b0;
            n_i        = '0;
            n_j        = '0;
            n_k        = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_done_a    <= 1'b0;
            r_done_b    <= 1'b0;
            r_ovf       <= 1'b0;
            r_unsorted  <= 1'b0;
            r_dup       <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt_a     <= n_cnt_a;
            r_cnt_b     <= n_cnt_b;
            r_done_a    <= n_done_a;
            r_done_b    <= n_done_b;
            r_ovf       <= n_ovf;
            r_unsorted  <= n_unsorted;
            r_i         <= n_i;
            r_j         <= n_j;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_dup <= i_cfg_data;
            end
        end
    end

    // stores: one write, one registered read addressed by the next head index
    always_ff @(posedge i_clk) begin
        if (sel_wr && !i_item.list_sel) begin
            mem_a[r_cnt_a[ADDR_W-1:0]] <= i_item.value;
            r_last_a                   <= i_item.value;
        end
        if (sel_wr && i_item.list_sel) begin
            mem_b[r_cnt_b[ADDR_W-1:0]] <= i_item.value;
            r_last_b                   <= i_item.value;
        end
        r_rd_a <= mem_a[n_i[ADDR_W-1:0]];
        r_rd_b <= mem_b[n_j[ADDR_W-1:0]];
        r_out  <= n_out;
    end

    assign o_result       = r_out;
    assign o_result_valid = r_out_valid;

endmodule

// File: rtl/sorted_list_merge_engine.sv
// Loading: one item per cycle, busy stays low until the item that closes both lists.
// After that item: a PRIME state sets up the store read ports, then one result per
// cycle from the compare/select stage in MERGE, each registered at the output.
// An unsorted list gives its single error result from the PRIME state instead.
// Busy rises with the closing transfer and falls as the last (or error) result registers.
// Synchronous active-low reset clears counts, flags and drop_duplicates; stores keep data.
// ----------------------------------------------------------------------------
// sorted_list_merge_engine
// Top level: sequencer, datapath and the duplicate-drop config port.
// ----------------------------------------------------------------------------
module sorted_list_merge_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  slme_pkg::t_in_item  i_item,
    output slme_pkg::t_out_item o_result,
    output logic                o_result_valid,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data
);
    import slme_pkg::*;

    `include "sorted_list_merge_engine_macros.svh"

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    slme_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    slme_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_item         (i_item),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_stat         (stat),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

    `SLME_ASSERT_IMP(a_result_in_busy, i_clk, i_rst_n, o_result_valid, $past(o_busy))
    `SLME_ASSERT_NXT(a_last_gap, i_clk, i_rst_n, o_result_valid && o_result.last, !o_result_valid)
    `SLME_ASSERT_IMP(a_busy_from_start, i_clk, i_rst_n, $rose(o_busy), $past(i_start))

endmodule

// File: tb/tb_sorted_list_merge_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_list_merge_engine
// Loads pairs of lists into the merge engine and checks every result against
// a predicted merge. Lists are sorted, unsorted, overflowing or mixed with
// items for an ended list. Duplicate dropping is switched on and off, and
// sender gaps vary by phase.
// ----------------------------------------------------------------------------
module tb_sorted_list_merge_engine;
    import slme_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 8;

    class merge_scoreboard;
        logic signed [31:0] first_vals[DEPTH];
        logic signed [31:0] second_vals[DEPTH];
        logic [CNT_W-1:0]   first_n;
        logic [CNT_W-1:0]   second_n;
        bit                 first_end;
        bit                 second_end;
        bit                 dropped;
        bit                 dedup;
        t_out_item          pending[$];
        int                 errors;
        int                 checked;
        int                 merges;
        int                 rejects;
        int                 overflows;

        function new();
            clear();
            dedup     = 1'b0;
            errors    = 0;
            checked   = 0;
            merges    = 0;
            rejects   = 0;
            overflows = 0;
        endfunction

        function void clear();
            first_n    = '0;
            second_n   = '0;
            first_end  = 1'b0;
            second_end = 1'b0;
            dropped    = 1'b0;
        endfunction

        function void set_dedup(bit v);
            dedup = v;
        endfunction

        function bit is_ascending(logic signed [31:0] vals[DEPTH], logic [CNT_W-1:0] n);
            for (int k = 1; k < n; k++) begin
                if (vals[k] < vals[k-1]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void build_results();
            t_out_item          e;
            int                 i;
            int                 j;
            int                 total;
            logic [1:0]         st;
            logic signed [31:0] a;
            logic signed [31:0] b;
            logic signed [31:0] v;
            if (!is_ascending(first_vals, first_n) || !is_ascending(second_vals, second_n)) begin
                e.merged_value = '0;
                e.last         = 1'b1;
                e.status       = ST_UNSORTED;
                pending.push_back(e);
                rejects++;
            end else begin
                st = dropped ? ST_OVERFLOW : ST_OK;
                if (dropped) overflows++;
                total = first_n + second_n;
                i = 0;
                j = 0;
                for (int k = 0; k < total; k++) begin
                    if (i < first_n && j < second_n) begin
                        a = first_vals[i];
                        b = second_vals[j];
                        if (dedup && a == b) begin
                            v = b;
                            i++;
                            j++;
                        end else if (a <= b) begin
                            v = a;
                            i++;
                        end else begin
                            v = b;
                            j++;
                        end
                    end else if (i < first_n) begin
                        v = first_vals[i];
                        i++;
                    end else if (j < second_n) begin
                        v = second_vals[j];
                        j++;
                    end else begin
                        v = '0;
                    end
                    e.merged_value = v;
                    e.last         = (k == total - 1);
                    e.status       = st;
                    pending.push_back(e);
                end
                merges++;
            end
            clear();
        endfunction

        function void note_item(t_in_item it);
            if (it.list_sel ? second_end : first_end) return;
            if (!it.list_sel) begin
                if (first_n < DEPTH) begin
                    first_vals[first_n] = it.value;
                    first_n++;
                end else begin
                    dropped = 1'b1;
                end
                if (it.end_of_list) first_end = 1'b1;
            end else begin
                if (second_n < DEPTH) begin
                    second_vals[second_n] = it.value;
                    second_n++;
                end else begin
                    dropped = 1'b1;
                end
                if (it.end_of_list) second_end = 1'b1;
            end
            if (first_end && second_end) build_results();
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result value=%0d last=%0b status=%0d",
                         $time, got.merged_value, got.last, got.status);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.merged_value !== want.merged_value) begin
                $display("%0t: merged_value mismatch, expected %0d, actual %0d",
                         $time, want.merged_value, got.merged_value);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last mismatch, expected %0b, actual %0b",
                         $time, want.last, got.last);
                errors++;
            end
            if (got.status !== want.status) begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    t_in_item  item = '0;
    logic      cfg_valid = 1'b0;
    logic      cfg_data = 1'b0;
    logic      busy;
    t_out_item result;
    logic      result_valid;
    logic      cfg_ready;

    merge_scoreboard sb;
    int              idle_pct = 0;
    int              items_sent = 0;
    int              idle_cycles = 0;
    int              qa[$];
    int              qb[$];

    sorted_list_merge_engine uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .i_item         (item),
        .o_result       (result),
        .o_result_valid (result_valid),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    // transfer monitor and watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            if (start && !busy) sb.note_item(item);
            if (result_valid) sb.check_result(result);
            if (cfg_valid && cfg_ready) sb.set_dedup(cfg_data);
            if ((start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic send_item(t_in_item it);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(bit v);
        start     <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // interleave qa and qb, optionally slipping in items for an ended list
    task automatic send_pair(int noise_pct);
        int       ia;
        int       ib;
        bit       pick_b;
        t_in_item it;
        ia = 0;
        ib = 0;
        while (ia < qa.size() || ib < qb.size()) begin
            if (((ia == qa.size()) != (ib == qb.size())) && $urandom_range(99) < noise_pct) begin
                it.list_sel    = (ia == qa.size()) ? 1'b0 : 1'b1;
                it.value       = $urandom;
                it.end_of_list = $urandom_range(1);
                send_item(it);
            end
            if (ia < qa.size() && ib < qb.size()) pick_b = $urandom_range(1);
            else pick_b = (ib < qb.size());
            it.list_sel    = pick_b;
            it.value       = pick_b ? qb[ib] : qa[ia];
            it.end_of_list = pick_b ? (ib == qb.size() - 1) : (ia == qa.size() - 1);
            if (pick_b) ib++;
            else ia++;
            send_item(it);
            items_sent++;
        end
    endtask

    function automatic void fill_list(ref int q[$], input int len, input bit ascending,
                                      input int mode);
        int corner_vals[4] = '{32'sh80000000, 32'sh7fffffff, 0, -1};
        q.delete();
        for (int k = 0; k < len; k++) begin
            case (mode)
                0: q.push_back($urandom_range(8) - 4);
                1: q.push_back($urandom);
                default: begin
                    if ($urandom_range(2) == 0) q.push_back(corner_vals[$urandom_range(3)]);
                    else q.push_back($urandom);
                end
            endcase
        end
        q.sort();
        if (!ascending) q.reverse();
    endfunction

    function automatic int pick_len();
        if ($urandom_range(11) == 0) return $urandom_range(DEPTH + 2, DEPTH - 1);
        return $urandom_range(6, 1);
    endfunction

    task automatic random_pair();
        int mode;
        mode = $urandom_range(2);
        fill_list(qa, pick_len(), $urandom_range(5) != 0, mode);
        fill_list(qb, pick_len(), $urandom_range(5) != 0, mode);
        send_pair(12);
    endtask

    initial begin
        t_in_item it;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, equal heads, unsorted lists, ended-list item
        write_cfg(1'b0);
        qa = '{32'sh80000000};
        qb = '{32'sh7fffffff};
        send_pair(0);
        qa = '{1, 2, 3};
        qb = '{2, 2, 5};
        send_pair(0);
        qa = '{5, 3};
        qb = '{1};
        send_pair(0);
        qa = '{-1};
        qb = '{3, 0};
        send_pair(0);
        it = '{list_sel: 1'b0, value: 7, end_of_list: 1'b1};
        send_item(it);
        items_sent++;
        it = '{list_sel: 1'b0, value: 9, end_of_list: 1'b0};
        send_item(it);
        it = '{list_sel: 1'b1, value: 7, end_of_list: 1'b1};
        send_item(it);
        items_sent++;
        drain();
        write_cfg(1'b1);
        qa = '{1, 2, 2, 4};
        qb = '{2, 2, 3};
        send_pair(0);
        qa = '{32'sh80000000, 0};
        qb = '{32'sh80000000, 32'sh7fffffff};
        send_pair(0);

        for (int phase = 0; phase < 3; phase++) begin
            int goal;
            drain();
            write_cfg(phase != 1);
            idle_pct = (phase == 0) ? 16 : (phase == 1) ? 64 : 0;
            if (phase == 0) begin
                fill_list(qa, DEPTH + 1, 1'b1, 1);
                fill_list(qb, 3, 1'b1, 0);
                send_pair(12);
            end else if (phase == 2) begin
                fill_list(qa, 2, 1'b1, 0);
                fill_list(qb, 4, 1'b0, 1);
                send_pair(12);
            end
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal) begin
                random_pair();
                if ($urandom_range(7) == 0) drain();
            end
        end

        drain();
        repeat (4) @(posedge clk);
        if (sb.pending.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, sb.pending.size());
            sb.errors++;
        end
        $display("Covered %0d list items: %0d merges (%0d with dropped elements), %0d rejected",
                 items_sent, sb.merges, sb.overflows, sb.rejects);
        $display("%0d results checked with duplicate dropping both on and off", sb.checked);
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
